[rtl/aiqb_pkg.sv]
// ----------------------------------------------------------------------------
// aiqb_pkg
// Shared types and constants of the adaptive IQ balancer: the word formats,
// the register indexes and the control word that the sequencer ROM holds.
// ----------------------------------------------------------------------------
package aiqb_pkg;

  // Sample format, Q1.(SampleWidth-1).
  localparam int SampleWidth    = 16;
  // Default width of each weight part, Q3.(WeightWidth-3).
  localparam int WeightWidthDef = 32;

  // Gain and phase registers are Q2.14.
  localparam int CorrWidth = 16;
  localparam int CorrFrac  = 14;
  localparam int StepWidth = 4;
  // The leak shift is the step shift plus this many bits.
  localparam int LeakExtra = 20;

  // Sequencer program.
  localparam int PcWidth = 5;
  localparam int ProgLen = 26;

  // Configuration port.
  localparam int CfgIdxWidth  = 2;
  localparam int CfgDataWidth = 16;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_PHASE = 2'd0,
    CFG_GAIN  = 2'd1,
    CFG_STEP  = 2'd2
  } cfg_idx_e;

  localparam logic signed [CorrWidth-1:0] PhaseReset = 16'sd0;
  localparam logic signed [CorrWidth-1:0] GainReset  = 16'sd16384;
  localparam logic [StepWidth-1:0]        StepReset  = 4'd2;

  typedef struct packed {
    logic signed [SampleWidth-1:0] in_i;
    logic signed [SampleWidth-1:0] in_q;
  } sample_in_t;

  typedef struct packed {
    logic signed [SampleWidth-1:0] out_i;
    logic signed [SampleWidth-1:0] out_q;
  } sample_out_t;

  // First multiplier operand. MA_NONE leaves the product register alone.
  typedef enum logic [2:0] {
    MA_NONE,
    MA_XI,
    MA_WR_LO,
    MA_WR_HI,
    MA_WI_LO,
    MA_WI_HI,
    MA_YR,
    MA_YI
  } mul_a_e;

  // Second multiplier operand.
  typedef enum logic [2:0] {
    MB_GAIN,
    MB_PHASE,
    MB_AI,
    MB_AQ,
    MB_YR,
    MB_YI
  } mul_b_e;

  // Accumulator operation, working on the product of the previous step.
  typedef enum logic [3:0] {
    AO_NOP,
    AO_LD_P,
    AO_ADD_P,
    AO_SUB_P,
    AO_ADD_PH,
    AO_SUB_PH,
    AO_LD_CORR,
    AO_LD_CORR_XQ,
    AO_FIN_YR,
    AO_FIN_YI,
    AO_LD_P2,
    AO_LEAK_R,
    AO_LEAK_I,
    AO_SUB_TW_R,
    AO_SUB_TW_I
  } acc_op_e;

  // Register that takes the accumulator at the end of the step.
  typedef enum logic [3:0] {
    DS_NONE,
    DS_AI,
    DS_AQ,
    DS_YR,
    DS_YI,
    DS_SQR,
    DS_SQI,
    DS_WR,
    DS_WI
  } dst_e;

  // How the step counter moves on.
  typedef enum logic [1:0] {
    SQ_NEXT,
    SQ_WAIT_IN,
    SQ_WAIT_OUT,
    SQ_END
  } seq_e;

  typedef struct packed {
    mul_a_e  ma;
    mul_b_e  mb;
    acc_op_e aop;
    dst_e    dst;
    seq_e    seq;
  } ctrl_t;

endpackage

[rtl/adaptive_iq_balancer_top.sv]
// ----------------------------------------------------------------------------
// adaptive_iq_balancer_top
// IQ imbalance correction: fixed gain and phase correction followed by an
// adaptive complex weight trained by leaky LMS, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake               word
//   in       input      in_valid_i / in_stall_o  in_data_i   (in_i, in_q)
//   out      output     out_valid_o / out_stall_i out_data_o (out_i, out_q)
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A word is accepted on the idle step and 25 working steps follow, so a new
// word is taken only once the sequencer is back on its idle step. The result
// enters the output register at the end of step 17; if the output register
// is still occupied then, the sequencer holds at that step and the word takes
// longer. The pace is set by the single shared multiplier and accumulator:
// every product of the correction, the weight product and the weight update
// passes through them in turn. Reset clears the sequencer, the handshake
// state and the weight and sets the correction registers to their reset
// values; no clearing pass is needed. A stall on the output holds the word in
// the output register; the sequencer finishes its weight update once the
// result has moved into it.
//
module adaptive_iq_balancer_top #(
  parameter int WeightWidth = aiqb_pkg::WeightWidthDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  aiqb_pkg::sample_in_t                   in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output aiqb_pkg::sample_out_t                  out_data_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [aiqb_pkg::CfgIdxWidth-1:0]       cfg_index_i,
  input  logic [aiqb_pkg::CfgDataWidth-1:0]      cfg_data_i
);
  import aiqb_pkg::*;

  // Sequencer program. Each step may start one product, fold the previous
  // product into the accumulator and park the accumulator in a register.
  // Steps 0..4   : capture, gain and phase correction.
  // Steps 4..10  : real part of w * conj(adj), then yr.
  // Steps 10..16 : imaginary part, then yi; y squared starts.
  // Step 17      : hand the result to the output register.
  // Steps 18..25 : y squared and the leaky update of both weight parts.
  localparam ctrl_t Ucode [2**PcWidth] = '{
    '{MA_NONE,  MB_GAIN,  AO_NOP,        DS_NONE, SQ_WAIT_IN},
    '{MA_XI,    MB_GAIN,  AO_NOP,        DS_NONE, SQ_NEXT},
    '{MA_XI,    MB_PHASE, AO_LD_CORR,    DS_NONE, SQ_NEXT},
    '{MA_NONE,  MB_GAIN,  AO_LD_CORR_XQ, DS_AI,   SQ_NEXT},
    '{MA_WR_LO, MB_AI,    AO_NOP,        DS_AQ,   SQ_NEXT},
    '{MA_WI_LO, MB_AQ,    AO_LD_P,       DS_NONE, SQ_NEXT},
    '{MA_WR_HI, MB_AI,    AO_ADD_P,      DS_NONE, SQ_NEXT},
    '{MA_WI_HI, MB_AQ,    AO_ADD_PH,     DS_NONE, SQ_NEXT},
    '{MA_NONE,  MB_GAIN,  AO_ADD_PH,     DS_NONE, SQ_NEXT},
    '{MA_NONE,  MB_GAIN,  AO_FIN_YR,     DS_NONE, SQ_NEXT},
    '{MA_WI_LO, MB_AI,    AO_NOP,        DS_YR,   SQ_NEXT},
    '{MA_WR_LO, MB_AQ,    AO_LD_P,       DS_NONE, SQ_NEXT},
    '{MA_WI_HI, MB_AI,    AO_SUB_P,      DS_NONE, SQ_NEXT},
    '{MA_WR_HI, MB_AQ,    AO_ADD_PH,     DS_NONE, SQ_NEXT},
    '{MA_YR,    MB_YR,    AO_SUB_PH,     DS_NONE, SQ_NEXT},
    '{MA_NONE,  MB_GAIN,  AO_FIN_YI,     DS_NONE, SQ_NEXT},
    '{MA_NONE,  MB_GAIN,  AO_LD_P,       DS_YI,   SQ_NEXT},
    '{MA_NONE,  MB_GAIN,  AO_NOP,        DS_NONE, SQ_WAIT_OUT},
    '{MA_YI,    MB_YI,    AO_NOP,        DS_NONE, SQ_NEXT},
    '{MA_YR,    MB_YI,    AO_SUB_P,      DS_NONE, SQ_NEXT},
    '{MA_NONE,  MB_GAIN,  AO_LD_P2,      DS_SQR,  SQ_NEXT},
    '{MA_NONE,  MB_GAIN,  AO_LEAK_R,     DS_SQI,  SQ_NEXT},
    '{MA_NONE,  MB_GAIN,  AO_SUB_TW_R,   DS_NONE, SQ_NEXT},
    '{MA_NONE,  MB_GAIN,  AO_LEAK_I,     DS_WR,   SQ_NEXT},
    '{MA_NONE,  MB_GAIN,  AO_SUB_TW_I,   DS_NONE, SQ_NEXT},
    '{MA_NONE,  MB_GAIN,  AO_NOP,        DS_WI,   SQ_END},
    '{MA_NONE,  MB_GAIN,  AO_NOP,        DS_NONE, SQ_END},
    '{MA_NONE,  MB_GAIN,  AO_NOP,        DS_NONE, SQ_END},
    '{MA_NONE,  MB_GAIN,  AO_NOP,        DS_NONE, SQ_END},
    '{MA_NONE,  MB_GAIN,  AO_NOP,        DS_NONE, SQ_END},
    '{MA_NONE,  MB_GAIN,  AO_NOP,        DS_NONE, SQ_END},
    '{MA_NONE,  MB_GAIN,  AO_NOP,        DS_NONE, SQ_END}
  };

  logic [PcWidth-1:0]          pc_d, pc_q;
  ctrl_t                       ctrl;
  logic                        in_acc;
  logic                        out_free;
  logic                        out_load;
  logic                        out_valid_d, out_valid_q;
  sample_out_t                 out_q;
  sample_out_t                 y;
  logic signed [CorrWidth-1:0] phase_q, gain_q;
  logic [StepWidth-1:0]        step_shift_q;

  assign ctrl = Ucode[pc_q];

  // A new word is taken only while the sequencer sits on its idle step.
  assign in_stall_o = (ctrl.seq != SQ_WAIT_IN);
  assign in_acc     = in_valid_i && !in_stall_o;

  // The result register is free when empty or being emptied this cycle.
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (ctrl.seq == SQ_WAIT_OUT) && out_free;

  always_comb begin
    pc_d = pc_q;
    case (ctrl.seq)
      SQ_NEXT: begin
        pc_d = pc_q + PcWidth'(1);
      end
      SQ_WAIT_IN: begin
        if (in_acc) begin
          pc_d = pc_q + PcWidth'(1);
        end
      end
      SQ_WAIT_OUT: begin
        if (out_free) begin
          pc_d = pc_q + PcWidth'(1);
        end
      end
      SQ_END: begin
        pc_d = '0;
      end
      default: begin
        pc_d = '0;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= y;
    end
  end

  // Configuration registers. Writes to an index outside the list are taken
  // and dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhaseReset;
      gain_q       <= GainReset;
      step_shift_q <= StepReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_PHASE: phase_q      <= cfg_data_i[CorrWidth-1:0];
        CFG_GAIN:  gain_q       <= cfg_data_i[CorrWidth-1:0];
        CFG_STEP:  step_shift_q <= cfg_data_i[StepWidth-1:0];
        default:   ;
      endcase
    end
  end

  aiqb_datapath #(
    .WeightWidth (WeightWidth)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .in_load_i    (in_acc),
    .in_data_i    (in_data_i),
    .phase_i      (phase_q),
    .gain_i       (gain_q),
    .step_shift_i (step_shift_q),
    .y_o          (y)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The sequencer never runs past the end of its program.
  a_pc_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q < PcWidth'(ProgLen))
    else $error("sequencer step beyond program");

  // An accepted word starts the program at its first working step.
  a_start_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> pc_q == PcWidth'(1))
    else $error("sequencer did not start after accepting a word");

  // A result appears only after the result step of the program.
  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl.seq == SQ_WAIT_OUT))
    else $error("result appeared outside the result step");

  // While the output is blocked, the sequencer holds at the result step.
  a_hold_on_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.seq == SQ_WAIT_OUT && out_valid_q && out_stall_i) |=> $stable(pc_q))
    else $error("sequencer moved past a blocked result");

endmodule

[rtl/aiqb_datapath.sv]
// ----------------------------------------------------------------------------
// aiqb_datapath
// Shared multiplier, product register, accumulator and working registers of
// the balancer, steered one control word at a time by the sequencer.
// ----------------------------------------------------------------------------
module aiqb_datapath #(
  parameter int WeightWidth = aiqb_pkg::WeightWidthDef
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  aiqb_pkg::ctrl_t                         ctrl_i,
  input  logic                                    in_load_i,
  input  aiqb_pkg::sample_in_t                    in_data_i,
  input  logic signed [aiqb_pkg::CorrWidth-1:0]   phase_i,
  input  logic signed [aiqb_pkg::CorrWidth-1:0]   gain_i,
  input  logic        [aiqb_pkg::StepWidth-1:0]   step_shift_i,
  output aiqb_pkg::sample_out_t                   y_o
);
  import aiqb_pkg::*;

  localparam int Sw      = SampleWidth;
  localparam int AdjW    = Sw + 3;
  localparam int YW      = AdjW + 4;
  localparam int LoW     = WeightWidth / 2;
  localparam int HiW     = WeightWidth - LoW;
  localparam int FracW   = WeightWidth - 3;
  localparam int MulW0   = (YW > LoW + 1) ? YW : LoW + 1;
  localparam int MulW1   = (MulW0 > HiW) ? MulW0 : HiW;
  localparam int MulW    = (MulW1 > CorrWidth) ? MulW1 : CorrWidth;
  localparam int PW      = 2 * MulW;
  localparam int SqW     = 2 * YW + 1;
  localparam int NetBase = 2 * (Sw - 1) - FracW;
  localparam int LshMax  = (NetBase < 0) ? -NetBase : 0;
  localparam int AccW0   = WeightWidth + AdjW + 1;
  localparam int AccW1   = SqW + LshMax + 2;
  localparam int AccW    = (AccW0 > AccW1) ? AccW0 : AccW1;

  logic signed [Sw-1:0]          xi_q, xq_q;
  logic signed [AdjW-1:0]        ai_q, aq_q;
  logic signed [YW-1:0]          yr_q, yi_q;
  logic signed [SqW-1:0]         sqr_q, sqi_q;
  logic signed [WeightWidth-1:0] wr_q, wi_q;
  logic signed [MulW-1:0]        mul_a, mul_b;
  logic signed [PW-1:0]          mul_p, prod_q;
  logic signed [AccW-1:0]        acc_d, acc_q;
  logic signed [AccW-1:0]        tw_r, tw_i;
  logic signed [7:0]             net;
  logic        [6:0]             net_mag;
  logic        [5:0]             leak_sh;

  function automatic logic signed [WeightWidth-1:0] sat_w(logic signed [AccW-1:0] v);
    logic [AccW-WeightWidth:0] top;
    top = v[AccW-1:WeightWidth-1];
    if (&top || ~|top) begin
      sat_w = v[WeightWidth-1:0];
    end else if (v[AccW-1]) begin
      sat_w = {1'b1, {(WeightWidth-1){1'b0}}};
    end else begin
      sat_w = {1'b0, {(WeightWidth-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [Sw-1:0] sat_y(logic signed [YW-1:0] v);
    logic [YW-Sw:0] top;
    top = v[YW-1:Sw-1];
    if (&top || ~|top) begin
      sat_y = v[Sw-1:0];
    end else if (v[YW-1]) begin
      sat_y = {1'b1, {(Sw-1){1'b0}}};
    end else begin
      sat_y = {1'b0, {(Sw-1){1'b1}}};
    end
  endfunction

  // Multiplier operands. Weights are split into an unsigned low half and a
  // signed high half so that the multiplier stays narrow.
  always_comb begin
    case (ctrl_i.ma)
      MA_XI:    mul_a = MulW'(xi_q);
      MA_WR_LO: mul_a = MulW'($signed({1'b0, wr_q[LoW-1:0]}));
      MA_WR_HI: mul_a = MulW'($signed(wr_q[WeightWidth-1:LoW]));
      MA_WI_LO: mul_a = MulW'($signed({1'b0, wi_q[LoW-1:0]}));
      MA_WI_HI: mul_a = MulW'($signed(wi_q[WeightWidth-1:LoW]));
      MA_YR:    mul_a = MulW'(yr_q);
      MA_YI:    mul_a = MulW'(yi_q);
      default:  mul_a = '0;
    endcase
  end

  always_comb begin
    case (ctrl_i.mb)
      MB_GAIN:  mul_b = MulW'(gain_i);
      MB_PHASE: mul_b = MulW'(phase_i);
      MB_AI:    mul_b = MulW'(ai_q);
      MB_AQ:    mul_b = MulW'(aq_q);
      MB_YR:    mul_b = MulW'(yr_q);
      MB_YI:    mul_b = MulW'(yi_q);
      default:  mul_b = '0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // The squared output is brought to the weight format with the step size
  // folded in; the net shift goes left when the weight has more fraction bits.
  assign net     = 8'(NetBase) + 8'(step_shift_i);
  assign net_mag = net[7] ? 7'(-net) : net[6:0];
  assign leak_sh = 6'(step_shift_i) + 6'(LeakExtra);
  assign tw_r    = net[7] ? (AccW'(sqr_q) <<< net_mag) : (AccW'(sqr_q) >>> net_mag);
  assign tw_i    = net[7] ? (AccW'(sqi_q) <<< net_mag) : (AccW'(sqi_q) >>> net_mag);

  always_comb begin
    case (ctrl_i.aop)
      AO_NOP:        acc_d = acc_q;
      AO_LD_P:       acc_d = AccW'(prod_q);
      AO_ADD_P:      acc_d = acc_q + AccW'(prod_q);
      AO_SUB_P:      acc_d = acc_q - AccW'(prod_q);
      AO_ADD_PH:     acc_d = acc_q + (AccW'(prod_q) <<< LoW);
      AO_SUB_PH:     acc_d = acc_q - (AccW'(prod_q) <<< LoW);
      AO_LD_CORR:    acc_d = AccW'(prod_q >>> CorrFrac);
      AO_LD_CORR_XQ: acc_d = AccW'(xq_q) + AccW'(prod_q >>> CorrFrac);
      AO_FIN_YR:     acc_d = AccW'(ai_q) + (acc_q >>> FracW);
      AO_FIN_YI:     acc_d = AccW'(aq_q) + (acc_q >>> FracW);
      AO_LD_P2:      acc_d = AccW'(prod_q) <<< 1;
      AO_LEAK_R:     acc_d = AccW'(wr_q) - AccW'(wr_q >>> leak_sh);
      AO_LEAK_I:     acc_d = AccW'(wi_q) - AccW'(wi_q >>> leak_sh);
      AO_SUB_TW_R:   acc_d = acc_q - tw_r;
      AO_SUB_TW_I:   acc_d = acc_q - tw_i;
      default:       acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_load_i) begin
      xi_q <= in_data_i.in_i;
      xq_q <= in_data_i.in_q;
    end
    if (ctrl_i.ma != MA_NONE) begin
      prod_q <= mul_p;
    end
    acc_q <= acc_d;
    case (ctrl_i.dst)
      DS_AI:   ai_q  <= acc_q[AdjW-1:0];
      DS_AQ:   aq_q  <= acc_q[AdjW-1:0];
      DS_YR:   yr_q  <= acc_q[YW-1:0];
      DS_YI:   yi_q  <= acc_q[YW-1:0];
      DS_SQR:  sqr_q <= acc_q[SqW-1:0];
      DS_SQI:  sqi_q <= acc_q[SqW-1:0];
      default: ;
    endcase
  end

  // The weight is the only state that survives from item to item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      wi_q <= '0;
    end else begin
      if (ctrl_i.dst == DS_WR) begin
        wr_q <= sat_w(acc_q);
      end
      if (ctrl_i.dst == DS_WI) begin
        wi_q <= sat_w(acc_q);
      end
    end
  end

  assign y_o.out_i = sat_y(yr_q);
  assign y_o.out_q = sat_y(yi_q);

endmodule
